// File: hw/rtl/vtpd_pkg.sv
// vtpd_pkg: shared types, widths and constants for the vector-to-polar block.
// No dependencies; every other file under hw/rtl refers to it by scoped names.
package vtpd_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int XY_W       = 32;
	localparam int ANG_W      = 32;
	localparam int GUARD      = 12;
	localparam int MAG_W      = 17;
	localparam int CD_W       = 16;
	localparam int CODE_W     = 4;
	localparam int MAX_STAGES = 32;

	// Inverse CORDIC gain, Q0.32.
	localparam logic [31:0] KINV = 32'h9B74EDA8;

	localparam logic [CD_W-1:0] CD_EAST  = 16'd0;
	localparam logic [CD_W-1:0] CD_NORTH = 16'd9000;
	localparam logic [CD_W-1:0] CD_WEST  = 16'd18000;
	localparam logic [CD_W-1:0] CD_SOUTH = 16'd27000;
	localparam logic [CD_W-1:0] CD_TURN  = 16'd36000;

	localparam logic [CODE_W-1:0] CMP_E    = 4'd0;
	localparam logic [CODE_W-1:0] CMP_NE   = 4'd1;
	localparam logic [CODE_W-1:0] CMP_N    = 4'd2;
	localparam logic [CODE_W-1:0] CMP_NW   = 4'd3;
	localparam logic [CODE_W-1:0] CMP_W    = 4'd4;
	localparam logic [CODE_W-1:0] CMP_SW   = 4'd5;
	localparam logic [CODE_W-1:0] CMP_S    = 4'd6;
	localparam logic [CODE_W-1:0] CMP_SE   = 4'd7;
	localparam logic [CODE_W-1:0] CMP_ZERO = 4'd8;

	// atan(2^-i) as a binary angle, 2^32 units per turn.
	localparam logic [ANG_W-1:0] ATAN_TAB [MAX_STAGES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] first_x;
		logic signed [COORD_BITS-1:0] first_y;
		logic signed [COORD_BITS-1:0] second_x;
		logic signed [COORD_BITS-1:0] second_y;
	} pts_t;

	typedef struct packed {
		logic [MAG_W-1:0]  magnitude;
		logic [CD_W-1:0]   angle_centideg;
		logic [CODE_W-1:0] compass;
	} polar_t;

	// Side information that rides along the rotation stages.
	typedef struct packed {
		logic              special;
		logic [CODE_W-1:0] code;
		logic [MAG_W-1:0]  mag;
		logic [CD_W-1:0]   cd;
	} meta_t;

endpackage

// File: hw/rtl/vtpd_front.sv
// vtpd_front: point difference, axis/zero classification and first-quadrant fold.
// Depends on vtpd_pkg.
module vtpd_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic                               valid_i,
	input  vtpd_pkg::pts_t                     pts_i,
	output logic                               valid_s2,
	output logic signed [vtpd_pkg::XY_W-1:0]   x_s2,
	output logic signed [vtpd_pkg::XY_W-1:0]   y_s2,
	output vtpd_pkg::meta_t                    meta_s2
);

	localparam int DW = vtpd_pkg::DIFF_W;

	logic                 valid_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;

	logic [DW-1:0]   ax;
	logic [DW-1:0]   ay;
	vtpd_pkg::meta_t meta_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dx_s1 <= DW'(pts_i.first_x) - DW'(pts_i.second_x);
			dy_s1 <= DW'(pts_i.first_y) - DW'(pts_i.second_y);
		end
	end

	assign ax = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
	assign ay = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);

	always_comb begin
		meta_d = '0;
		if (dx_s1 == '0 && dy_s1 == '0) begin
			meta_d.special = 1'b1;
			meta_d.code    = vtpd_pkg::CMP_ZERO;
		end else if (dy_s1 == '0) begin
			meta_d.special = 1'b1;
			meta_d.mag     = vtpd_pkg::MAG_W'(ax);
			meta_d.cd      = dx_s1[DW-1] ? vtpd_pkg::CD_WEST : vtpd_pkg::CD_EAST;
			meta_d.code    = dx_s1[DW-1] ? vtpd_pkg::CMP_W : vtpd_pkg::CMP_E;
		end else if (dx_s1 == '0) begin
			meta_d.special = 1'b1;
			meta_d.mag     = vtpd_pkg::MAG_W'(ay);
			meta_d.cd      = dy_s1[DW-1] ? vtpd_pkg::CD_SOUTH : vtpd_pkg::CD_NORTH;
			meta_d.code    = dy_s1[DW-1] ? vtpd_pkg::CMP_S : vtpd_pkg::CMP_N;
		end else if (!dx_s1[DW-1] && !dy_s1[DW-1]) begin
			meta_d.code = vtpd_pkg::CMP_NE;
		end else if (dx_s1[DW-1] && !dy_s1[DW-1]) begin
			meta_d.code = vtpd_pkg::CMP_NW;
		end else if (dx_s1[DW-1]) begin
			meta_d.code = vtpd_pkg::CMP_SW;
		end else begin
			meta_d.code = vtpd_pkg::CMP_SE;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s2    <= $signed({{(vtpd_pkg::XY_W - DW - vtpd_pkg::GUARD){1'b0}}, ax,
				{vtpd_pkg::GUARD{1'b0}}});
			y_s2    <= $signed({{(vtpd_pkg::XY_W - DW - vtpd_pkg::GUARD){1'b0}}, ay,
				{vtpd_pkg::GUARD{1'b0}}});
			meta_s2 <= meta_d;
		end
	end

endmodule

// File: hw/rtl/vtpd_rot.sv
// vtpd_rot: one registered CORDIC vectoring iteration at shift IDX.
// Depends on vtpd_pkg.
module vtpd_rot #(
	parameter int IDX = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic                                valid_i,
	input  logic signed [vtpd_pkg::XY_W-1:0]    x_i,
	input  logic signed [vtpd_pkg::XY_W-1:0]    y_i,
	input  logic signed [vtpd_pkg::ANG_W-1:0]   z_i,
	input  vtpd_pkg::meta_t                     meta_i,
	output logic                                valid_o,
	output logic signed [vtpd_pkg::XY_W-1:0]    x_o,
	output logic signed [vtpd_pkg::XY_W-1:0]    y_o,
	output logic signed [vtpd_pkg::ANG_W-1:0]   z_o,
	output vtpd_pkg::meta_t                     meta_o
);

	logic signed [vtpd_pkg::XY_W-1:0]  xs;
	logic signed [vtpd_pkg::XY_W-1:0]  ys;
	logic signed [vtpd_pkg::ANG_W-1:0] step;

	assign xs   = x_i >>> IDX;
	assign ys   = y_i >>> IDX;
	assign step = $signed(vtpd_pkg::ATAN_TAB[IDX]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (advance) begin
			valid_o <= valid_i;
		end
	end

	// Rotate toward the x axis: the sign of y picks the direction.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (!y_i[vtpd_pkg::XY_W-1]) begin
				x_o <= x_i + ys;
				y_o <= y_i - xs;
				z_o <= z_i + step;
			end else begin
				x_o <= x_i - ys;
				y_o <= y_i + xs;
				z_o <= z_i - step;
			end
			meta_o <= meta_i;
		end
	end

endmodule

// File: hw/rtl/vtpd_post.sv
// vtpd_post: gain correction, quadrant unfold and scaling to hundredths of a degree.
// Depends on vtpd_pkg.
module vtpd_post (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic                                valid_i,
	input  logic signed [vtpd_pkg::XY_W-1:0]    x_i,
	input  logic signed [vtpd_pkg::ANG_W-1:0]   z_i,
	input  vtpd_pkg::meta_t                     meta_i,
	output logic                                valid_s3,
	output vtpd_pkg::polar_t                    res_s3
);

	localparam int AW = vtpd_pkg::ANG_W;
	localparam int MPW = vtpd_pkg::XY_W + 32;
	localparam int APW = AW + vtpd_pkg::CD_W;

	logic                        valid_s1;
	logic                        valid_s2;
	logic [MPW-1:0]              mprod_s1;
	logic [AW-1:0]               t_s1;
	vtpd_pkg::meta_t             meta_s1;
	logic [vtpd_pkg::MAG_W-1:0]  mag_s2;
	logic [APW-1:0]              aprod_s2;
	vtpd_pkg::meta_t             meta_s2;

	logic [AW-1:0]               zu;
	logic [AW-1:0]               t_d;
	logic [32:0]                 mag_sum;
	logic [APW:0]                cd_sum;
	logic [vtpd_pkg::CD_W:0]     cd_raw;
	logic [vtpd_pkg::CD_W-1:0]   cd_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign zu = $unsigned(z_i);

	// Unfold modulo one turn.
	always_comb begin
		case (meta_i.code)
			vtpd_pkg::CMP_NE: t_d = zu;
			vtpd_pkg::CMP_NW: t_d = {1'b1, {(AW-1){1'b0}}} - zu;
			vtpd_pkg::CMP_SW: t_d = {1'b1, {(AW-1){1'b0}}} + zu;
			default:          t_d = '0 - zu;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mprod_s1 <= MPW'($unsigned(x_i)) * MPW'(vtpd_pkg::KINV);
			t_s1     <= t_d;
			meta_s1  <= meta_i;
		end
	end

	assign mag_sum = {1'b0, mprod_s1[63:32]} + 33'(1 << (vtpd_pkg::GUARD - 1));

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s2   <= mag_sum[vtpd_pkg::GUARD +: vtpd_pkg::MAG_W];
			aprod_s2 <= APW'(t_s1) * APW'(vtpd_pkg::CD_TURN);
			meta_s2  <= meta_s1;
		end
	end

	assign cd_sum  = {1'b0, aprod_s2} + ((APW+1)'(1) << (AW - 1));
	assign cd_raw  = cd_sum[AW +: (vtpd_pkg::CD_W + 1)];
	assign cd_wrap = (cd_raw >= {1'b0, vtpd_pkg::CD_TURN})
		? vtpd_pkg::CD_W'(cd_raw - {1'b0, vtpd_pkg::CD_TURN})
		: vtpd_pkg::CD_W'(cd_raw);

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s3.compass <= meta_s2.code;
			if (meta_s2.special) begin
				res_s3.magnitude      <= meta_s2.mag;
				res_s3.angle_centideg <= meta_s2.cd;
			end else begin
				res_s3.magnitude      <= mag_s2;
				res_s3.angle_centideg <= cd_wrap;
			end
		end
	end

endmodule

// File: hw/rtl/vtpd_obuf.sv
// vtpd_obuf: output register plus skid entry; gives the pipeline a registered ready.
// Depends on vtpd_pkg.
module vtpd_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	input  vtpd_pkg::polar_t up_data,
	output logic             up_ready,
	output logic             dn_valid,
	input  logic             dn_ready,
	output vtpd_pkg::polar_t dn_data
);

	logic             skid_valid_q;
	vtpd_pkg::polar_t skid_q;

	assign up_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (dn_ready || !dn_valid) begin
			// Drain the skid entry first.
			dn_valid     <= skid_valid_q || up_valid;
			skid_valid_q <= 1'b0;
		end else if (up_valid && up_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dn_ready || !dn_valid) begin
			dn_data <= skid_valid_q ? skid_q : up_data;
		end else if (up_valid && up_ready) begin
			skid_q <= up_data;
		end
	end

endmodule

// File: hw/rtl/vector_to_polar_direction.sv
// vector_to_polar_direction: top level, difference of two points to magnitude,
// angle and compass code. Depends on vtpd_pkg, vtpd_front, vtpd_rot, vtpd_post, vtpd_obuf.
//
// Usage:
//   pts beat (pts_valid/pts_ready) carries two signed Q8.8 points; the block forms
//   dx = first_x - second_x, dy = first_y - second_y. Each pts beat yields exactly
//   one polar beat (polar_valid/polar_ready): magnitude in the coordinate LSB,
//   angle counterclockwise from +x in 0.01 degree (0..35999), compass code 0..7,
//   or 8 for a zero vector.
//   Throughput: one beat per cycle while the output side does not stall. A beat passes
//   from the accepting edge to polar_valid through the pipeline in order:
//   two front stages, one stage per CORDIC iteration (up to 32 run), three post
//   stages and the output register.
//   Stall: when the receiver holds polar_ready low, one more beat lands in the
//   skid entry, then pts_ready drops and the whole pipeline holds in place;
//   nothing is dropped or repeated. pts_ready is driven from a register.
//   Reset (arst_n low) clears all valid bits; in-flight beats are discarded.
module vector_to_polar_direction #(
	parameter int CORDIC_STAGES = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pts_valid,
	output logic             pts_ready,
	input  vtpd_pkg::pts_t   pts,
	output logic             polar_valid,
	input  logic             polar_ready,
	output vtpd_pkg::polar_t polar
);

	// Iterations past 32 add nothing; clamp them.
	localparam int NSTG = (CORDIC_STAGES > vtpd_pkg::MAX_STAGES) ?
		vtpd_pkg::MAX_STAGES : CORDIC_STAGES;

	logic                               advance;
	logic                               rot_valid [NSTG+1];
	logic signed [vtpd_pkg::XY_W-1:0]   rot_x     [NSTG+1];
	logic signed [vtpd_pkg::XY_W-1:0]   rot_y     [NSTG+1];
	logic signed [vtpd_pkg::ANG_W-1:0]  rot_z     [NSTG+1];
	vtpd_pkg::meta_t                    rot_meta  [NSTG+1];
	logic                               post_valid;
	vtpd_pkg::polar_t                   post_res;

	// Advance every stage together; hold all when the output side is full.
	assign pts_ready = advance;

	vtpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_i  (pts_valid),
		.pts_i    (pts),
		.valid_s2 (rot_valid[0]),
		.x_s2     (rot_x[0]),
		.y_s2     (rot_y[0]),
		.meta_s2  (rot_meta[0])
	);

	// Start angle accumulation from zero.
	assign rot_z[0] = '0;

	for (genvar i = 0; i < NSTG; i++) begin : g_rot
		vtpd_rot #(
			.IDX (i)
		) u_rot (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.valid_i (rot_valid[i]),
			.x_i     (rot_x[i]),
			.y_i     (rot_y[i]),
			.z_i     (rot_z[i]),
			.meta_i  (rot_meta[i]),
			.valid_o (rot_valid[i+1]),
			.x_o     (rot_x[i+1]),
			.y_o     (rot_y[i+1]),
			.z_o     (rot_z[i+1]),
			.meta_o  (rot_meta[i+1])
		);
	end

	vtpd_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_i  (rot_valid[NSTG]),
		.x_i      (rot_x[NSTG]),
		.z_i      (rot_z[NSTG]),
		.meta_i   (rot_meta[NSTG]),
		.valid_s3 (post_valid),
		.res_s3   (post_res)
	);

	vtpd_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (post_valid),
		.up_data  (post_res),
		.up_ready (advance),
		.dn_valid (polar_valid),
		.dn_ready (polar_ready),
		.dn_data  (polar)
	);

endmodule
